### rtl/ttl_pkg.sv
// shared types and constants of the terminal text layout filter
// no dependencies; imported by every other file of the block
package ttl_pkg;

	// default layout limits, handed down from the top level
	localparam int MAX_LINES_DEF   = 8;
	localparam int MAX_COLUMNS_DEF = 64;

	// field widths of the beats
	localparam int BYTE_W   = 8;
	localparam int CP_W     = 21;
	localparam int LINE_IDX_W = 3;
	localparam int COL_IDX_W  = 6;

	// configuration port
	localparam int CFG_DATA_W = 7;
	localparam int CFG_COLS_W = 7;
	localparam int CFG_LINES_W = 4;

	localparam logic CFG_IDX_COLUMNS = 1'b0;
	localparam logic CFG_IDX_LINES   = 1'b1;

	localparam logic [CFG_COLS_W-1:0]  COLS_RESET  = 7'd25;
	localparam logic [CFG_LINES_W-1:0] LINES_RESET = 4'd4;

	// event kinds
	localparam logic EV_GLYPH = 1'b0;
	localparam logic EV_CLEAR = 1'b1;

	localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;

	// output queue
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = 2;
	localparam int OUTQ_CNT_W = 3;

	typedef struct packed {
		logic                  event_kind;
		logic [CP_W-1:0]       code_point;
		logic [LINE_IDX_W-1:0] line_index;
		logic [COL_IDX_W-1:0]  column_index;
	} result_t;

	// results of one byte: zero, one or two
	typedef struct packed {
		logic [1:0] n_results;
		result_t    first;
		result_t    second;
	} step_out_t;

endpackage

### rtl/ttl_if.sv
// handshake channels of the terminal text layout filter
// depends on ttl_pkg for the field widths
interface ttl_byte_if import ttl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;

	modport source(output valid, output text_byte, input ready);
	modport sink(input valid, input text_byte, output ready);
endinterface

interface ttl_event_if import ttl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  event_kind;
	logic [CP_W-1:0]       code_point;
	logic [LINE_IDX_W-1:0] line_index;
	logic [COL_IDX_W-1:0]  column_index;

	modport source(output valid, output event_kind, output code_point,
		output line_index, output column_index, input ready);
	modport sink(input valid, input event_kind, input code_point,
		input line_index, input column_index, output ready);
endinterface

### rtl/ttl_step.sv
// per-byte escape stripping, utf-8 decoding and layout, with the layout state
// depends on ttl_pkg
module ttl_step import ttl_pkg::*; #(
	parameter int MAX_LINES   = MAX_LINES_DEF,
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  logic [BYTE_W-1:0]      text_byte,
	input  logic [CFG_COLS_W-1:0]  columns_per_line,
	input  logic [CFG_LINES_W-1:0] lines_in_use,
	output step_out_t              res
);

	localparam int LW = $clog2(MAX_LINES + 1);
	localparam int CW = $clog2(MAX_COLUMNS + 1);

	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_ESC   = 2'd1;
	localparam logic [1:0] MODE_CSI   = 2'd2;

	logic [1:0]      mode_q, mode_d;
	logic            saw2_q, saw2_d;
	logic [CP_W-1:0] partial_q, partial_d, partial_n;
	logic [1:0]      expect_q, expect_d;
	logic [LW-1:0]   line_q, line_d, line_w, llim;
	logic [CW-1:0]   col_q, col_d, col_w, clim;
	logic            skip_q, skip_d;
	logic            ended_q, ended_d;

	logic            clear, newline, place_a, place_b, cont;
	logic [CP_W-1:0] cp_a, cp_b, cpx;
	logic [7:0]      b;

	assign b = text_byte;

	assign clim = (8'(columns_per_line) < 8'(MAX_COLUMNS)) ?
		CW'(columns_per_line) : CW'(MAX_COLUMNS);
	assign llim = (5'(lines_in_use) < 5'(MAX_LINES)) ?
		LW'(lines_in_use) : LW'(MAX_LINES);

	assign partial_n = {partial_q[CP_W-7:0], b[5:0]};

	// parse the byte
	always_comb begin
		mode_d    = mode_q;
		saw2_d    = saw2_q;
		partial_d = partial_q;
		expect_d  = expect_q;
		skip_d    = skip_q;
		ended_d   = ended_q;
		clear     = 1'b0;
		newline   = 1'b0;
		place_a   = 1'b0;
		place_b   = 1'b0;
		cont      = 1'b0;
		cp_a      = CP_REPLACEMENT;
		cp_b      = CP_W'(b);
		if (fire) begin
			case (mode_q)
				MODE_ESC: begin
					if (b == 8'h5B) begin
						mode_d = MODE_CSI;
						saw2_d = 1'b0;
					end else if (b == 8'h63) begin
						clear = 1'b1;
					end else begin
						mode_d = MODE_PLAIN;
					end
				end
				MODE_CSI: begin
					if (b < 8'h40) begin
						if (b == 8'h32) saw2_d = 1'b1;
					end else begin
						mode_d = MODE_PLAIN;
						if ((b inside {8'h48, 8'h66}) || (b == 8'h4A && saw2_q))
							clear = 1'b1;
					end
				end
				default: begin
					if (b == 8'h1B) begin
						mode_d = MODE_ESC;
						skip_d = 1'b0;
					end else if (skip_q && (b inside {8'h0A, 8'h0D})) begin
						skip_d = 1'b1;
					end else begin
						skip_d = 1'b0;
						if (!ended_q) begin
							if (expect_q != 2'd0) begin
								if (b[7:6] == 2'b10) begin
									cont     = 1'b1;
									expect_d = expect_q - 2'd1;
									if (expect_q == 2'd1) begin
										place_a   = 1'b1;
										cp_a      = partial_n;
										partial_d = '0;
									end else begin
										partial_d = partial_n;
									end
								end else begin
									// broken sequence, then decode this byte afresh
									place_a   = 1'b1;
									expect_d  = 2'd0;
									partial_d = '0;
								end
							end
							if (!cont) begin
								if (b == 8'h00) begin
									ended_d = 1'b1;
								end else if (b == 8'h0A) begin
									newline = 1'b1;
								end else if (b < 8'h80) begin
									place_b = 1'b1;
								end else if (b[7:5] == 3'b110) begin
									partial_d = CP_W'(b[4:0]);
									expect_d  = 2'd1;
								end else if (b[7:4] == 4'b1110) begin
									partial_d = CP_W'(b[3:0]);
									expect_d  = 2'd2;
								end else if (b[7:3] == 5'b11110) begin
									partial_d = CP_W'(b[2:0]);
									expect_d  = 2'd3;
								end else begin
									place_b = 1'b1;
									cp_b    = CP_REPLACEMENT;
								end
							end
						end
					end
				end
			endcase
		end
	end

	// place glyphs against the limits
	always_comb begin
		res    = '0;
		line_w = line_q;
		col_w  = col_q;
		cpx    = '0;
		if (clear) begin
			res.n_results        = 2'd1;
			res.first.event_kind = EV_CLEAR;
			line_w = '0;
			col_w  = '0;
		end else begin
			if (place_a && cp_a != 21'h0D) begin
				cpx = (cp_a == 21'h09) ? 21'h20 : cp_a;
				if (line_w < llim && col_w < clim) begin
					res.n_results   = 2'd1;
					res.first.event_kind   = EV_GLYPH;
					res.first.code_point   = cpx;
					res.first.line_index   = LINE_IDX_W'(line_w);
					res.first.column_index = COL_IDX_W'(col_w);
					col_w = col_w + CW'(1);
				end
			end
			if (newline) begin
				if (line_w < llim) line_w = line_w + LW'(1);
				col_w = '0;
			end
			if (place_b && cp_b != 21'h0D) begin
				cpx = (cp_b == 21'h09) ? 21'h20 : cp_b;
				if (line_w < llim && col_w < clim) begin
					if (res.n_results == 2'd0) begin
						res.first.event_kind   = EV_GLYPH;
						res.first.code_point   = cpx;
						res.first.line_index   = LINE_IDX_W'(line_w);
						res.first.column_index = COL_IDX_W'(col_w);
					end else begin
						res.second.event_kind   = EV_GLYPH;
						res.second.code_point   = cpx;
						res.second.line_index   = LINE_IDX_W'(line_w);
						res.second.column_index = COL_IDX_W'(col_w);
					end
					res.n_results = res.n_results + 2'd1;
					col_w = col_w + CW'(1);
				end
			end
		end
		line_d = line_w;
		col_d  = col_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_PLAIN;
			saw2_q    <= 1'b0;
			partial_q <= '0;
			expect_q  <= 2'd0;
			line_q    <= '0;
			col_q     <= '0;
			skip_q    <= 1'b1;
			ended_q   <= 1'b0;
		end else if (clear) begin
			mode_q    <= MODE_PLAIN;
			saw2_q    <= 1'b0;
			partial_q <= '0;
			expect_q  <= 2'd0;
			line_q    <= '0;
			col_q     <= '0;
			skip_q    <= 1'b1;
			ended_q   <= 1'b0;
		end else begin
			mode_q    <= mode_d;
			saw2_q    <= saw2_d;
			partial_q <= partial_d;
			expect_q  <= expect_d;
			line_q    <= line_d;
			col_q     <= col_d;
			skip_q    <= skip_d;
			ended_q   <= ended_d;
		end
	end

endmodule

### rtl/ttl_out_fifo.sv
// small result queue: takes up to two results a cycle, gives one beat a cycle while the sink is ready
// depends on ttl_pkg and ttl_if
module ttl_out_fifo import ttl_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  step_out_t     push,
	output logic          room,
	ttl_event_if.source   events
);

	result_t                entry_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0]  wr_q, rd_q, wr_next;
	logic [OUTQ_CNT_W-1:0]  cnt_q;
	logic                   pop;
	result_t                head;

	assign wr_next = wr_q + OUTQ_PTR_W'(1);
	// room for two whatever the sink does this cycle
	assign room = cnt_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
	assign pop  = events.valid && events.ready;
	assign head = entry_q[rd_q];

	assign events.valid        = cnt_q != '0;
	assign events.event_kind   = head.event_kind;
	assign events.code_point   = head.code_point;
	assign events.line_index   = head.line_index;
	assign events.column_index = head.column_index;

	always_ff @(posedge clk) begin
		if (push.n_results != 2'd0) entry_q[wr_q] <= push.first;
		if (push.n_results == 2'd2) entry_q[wr_next] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + OUTQ_PTR_W'(push.n_results);
			if (pop) rd_q <= rd_q + OUTQ_PTR_W'(1);
			cnt_q <= cnt_q + OUTQ_CNT_W'(push.n_results) - OUTQ_CNT_W'(pop);
		end
	end

endmodule

### rtl/terminal_text_layout_filter.sv
// terminal text layout filter: bytes in, glyph placements and clear events out
// a byte accepted into the input register passes the step logic once the queue has room, then waits in the result queue
// throughput: one byte per cycle while the queue has room; a byte with two results costs one extra output beat
// the rate is set by the single input register feeding the step logic
// reset (arst_n low) empties the queue, restores 25 columns and 4 lines, plain text mode
// depends on ttl_pkg, ttl_if, ttl_step and ttl_out_fifo
module terminal_text_layout_filter import ttl_pkg::*; #(
	parameter int MAX_LINES   = MAX_LINES_DEF,
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ttl_byte_if.sink              text,
	ttl_event_if.source           events
);

	// configuration registers, unused high bits dropped on write
	logic [CFG_COLS_W-1:0]  cols_q;
	logic [CFG_LINES_W-1:0] lines_q;

	// input stage: one byte waiting for the step logic
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic      room;
	logic      advance;
	logic      take;
	step_out_t step_res;

	// the byte in the stage is processed once the queue can hold both results
	assign advance    = valid_s1 && room;
	// a new beat enters while the old one leaves, so bytes flow back to back while the queue has room
	assign text.ready = !valid_s1 || room;
	assign take       = text.valid && text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q  <= COLS_RESET;
			lines_q <= LINES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_COLUMNS: cols_q  <= cfg_data[CFG_COLS_W-1:0];
				CFG_IDX_LINES:   lines_q <= cfg_data[CFG_LINES_W-1:0];
				default:         cols_q  <= cols_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (take) byte_s1 <= text.text_byte;
	end

	// escape stripping, decoding and layout in one pass; the state lives here
	ttl_step #(
		.MAX_LINES   (MAX_LINES),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_step (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (advance),
		.text_byte        (byte_s1),
		.columns_per_line (cols_q),
		.lines_in_use     (lines_q),
		.res              (step_res)
	);

	// result queue parts the step logic from a stalling sink
	ttl_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step_res),
		.room   (room),
		.events (events)
	);

endmodule
